// ----- design/ash_pkg.sv -----
package ash_pkg;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned SIGN_POS  = WORD_BITS - 1;

    localparam logic [3:0] KIND_LSL  = 4'd0;
    localparam logic [3:0] KIND_LSR  = 4'd1;
    localparam logic [3:0] KIND_ASR  = 4'd2;
    localparam logic [3:0] KIND_ROR  = 4'd3;
    localparam logic [3:0] KIND_TEST = 4'd4;
    localparam logic [3:0] KIND_ADD  = 4'd5;
    localparam logic [3:0] KIND_SUB  = 4'd6;
    localparam logic [3:0] KIND_ADC  = 4'd7;
    localparam logic [3:0] KIND_SBC  = 4'd8;

    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    typedef struct packed {
        logic [3:0]           kind;
        logic [WORD_BITS-1:0] operand_a;
        logic [WORD_BITS-1:0] operand_a_high;
        logic [WORD_BITS-1:0] operand_b;
        logic [7:0]           shift_amount;
        logic                 immediate_form;
        logic                 wide_test;
        logic                 set_flags;
    } op_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] result;
        logic [WORD_BITS-1:0] result_high;
        logic                 flag_n;
        logic                 flag_z;
        logic                 flag_c;
        logic                 flag_v;
    } res_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic                 carry;
        logic                 carry_wr;
    } shift_out_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic                 carry;
        logic                 overflow;
    } alu_out_t;

endpackage

// ----- design/arm_shifter_alu_flags.sv -----
// An accepted input goes to the input register, its result to the result register.
// Throughput: one transaction per cycle unless res_stall holds a valid result; the flags are
// read and written in the single execute stage between the input and result registers.
// Reset: rst_n clears both valid bits and the four condition flags at once.
module arm_shifter_alu_flags (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_stall,
    input  ash_pkg::op_t  op,
    output logic          res_valid,
    input  logic          res_stall,
    output ash_pkg::res_t res
);
    import ash_pkg::*;

    op_t        op_reg;
    logic       op_valid_reg;
    logic       op_valid_next;
    res_t       res_reg;
    res_t       res_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    flags_t     flags_reg;
    flags_t     flags_next;
    logic       accept;
    logic       advance;
    shift_out_t shift_out;
    alu_out_t   alu_out;
    logic       subtract;
    logic       use_carry;

    assign advance  = op_valid_reg && (!res_valid_reg || !res_stall);
    assign op_stall = op_valid_reg && !advance;
    assign accept   = op_valid && !op_stall;

    assign subtract  = (op_reg.kind == KIND_SUB) || (op_reg.kind == KIND_SBC);
    assign use_carry = (op_reg.kind == KIND_ADC) || (op_reg.kind == KIND_SBC);

    ash_shifter u_shifter (
        .mode      (op_reg.kind[1:0]),
        .value     (op_reg.operand_a),
        .amount    (op_reg.shift_amount),
        .imm       (op_reg.immediate_form),
        .carry_in  (flags_reg.c),
        .shift_out (shift_out)
    );

    ash_alu u_alu (
        .a         (op_reg.operand_a),
        .b         (op_reg.operand_b),
        .subtract  (subtract),
        .use_carry (use_carry),
        .carry_in  (flags_reg.c),
        .alu_out   (alu_out)
    );

    always_comb
    begin
        flags_next           = flags_reg;
        res_next.result      = '0;
        res_next.result_high = '0;
        case (op_reg.kind)
            KIND_LSL, KIND_LSR, KIND_ASR, KIND_ROR:
            begin
                res_next.result = shift_out.value;
                if (op_reg.set_flags && shift_out.carry_wr)
                begin
                    flags_next.c = shift_out.carry;
                end
            end
            KIND_TEST:
            begin
                res_next.result = op_reg.operand_a;
                if (op_reg.wide_test)
                begin
                    res_next.result_high = op_reg.operand_a_high;
                end
                if (op_reg.set_flags)
                begin
                    if (op_reg.wide_test)
                    begin
                        flags_next.n = op_reg.operand_a_high[SIGN_POS];
                        flags_next.z = ((op_reg.operand_a | op_reg.operand_a_high) == '0);
                    end
                    else
                    begin
                        flags_next.n = op_reg.operand_a[SIGN_POS];
                        flags_next.z = (op_reg.operand_a == '0);
                    end
                end
            end
            KIND_ADD, KIND_SUB, KIND_ADC, KIND_SBC:
            begin
                res_next.result = alu_out.value;
                if (op_reg.set_flags)
                begin
                    flags_next.n = alu_out.value[SIGN_POS];
                    flags_next.z = (alu_out.value == '0);
                    flags_next.c = alu_out.carry;
                    flags_next.v = alu_out.overflow;
                end
            end
            default:
            begin
                res_next.result = '0;
            end
        endcase
        res_next.flag_n = flags_next.n;
        res_next.flag_z = flags_next.z;
        res_next.flag_c = flags_next.c;
        res_next.flag_v = flags_next.v;
    end

    always_comb
    begin
        if (accept)
        begin
            op_valid_next = 1'b1;
        end
        else if (advance)
        begin
            op_valid_next = 1'b0;
        end
        else
        begin
            op_valid_next = op_valid_reg;
        end

        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- design/ash_shifter.sv -----
module ash_shifter (
    input  logic [1:0]               mode,
    input  logic [31:0]              value,
    input  logic [7:0]               amount,
    input  logic                     imm,
    input  logic                     carry_in,
    output ash_pkg::shift_out_t      shift_out
);
    import ash_pkg::*;

    logic [4:0]  shamt;
    logic        zero_amt;
    logic        exact;
    logic        big;
    logic [32:0] lsl_w;
    logic [32:0] lsr_w;
    logic [32:0] asr_w;
    logic [63:0] ror_w;

    assign shamt    = amount[4:0];
    assign zero_amt = (amount == 8'd0);
    assign exact    = (amount == 8'd32);
    assign big      = |amount[7:5];

    assign lsl_w = {1'b0, value} << shamt;
    assign lsr_w = {value, 1'b0} >> shamt;
    assign asr_w = 33'($signed({value, 1'b0}) >>> shamt);
    assign ror_w = {value, value} >> shamt;

    always_comb
    begin
        shift_out.value    = value;
        shift_out.carry    = carry_in;
        shift_out.carry_wr = 1'b1;
        if (zero_amt && (!imm || mode == SHIFT_LSL))
        begin
            shift_out.carry_wr = 1'b0;
        end
        else
        begin
            case (mode)
                SHIFT_LSL:
                begin
                    if (big)
                    begin
                        shift_out.value = '0;
                        shift_out.carry = exact & value[0];
                    end
                    else
                    begin
                        shift_out.value = lsl_w[31:0];
                        shift_out.carry = lsl_w[32];
                    end
                end
                SHIFT_LSR:
                begin
                    if (big || zero_amt)
                    begin
                        shift_out.value = '0;
                        shift_out.carry = (exact | zero_amt) & value[SIGN_POS];
                    end
                    else
                    begin
                        shift_out.value = lsr_w[32:1];
                        shift_out.carry = lsr_w[0];
                    end
                end
                SHIFT_ASR:
                begin
                    if (big || zero_amt)
                    begin
                        shift_out.value = {WORD_BITS{value[SIGN_POS]}};
                        shift_out.carry = value[SIGN_POS];
                    end
                    else
                    begin
                        shift_out.value = asr_w[32:1];
                        shift_out.carry = asr_w[0];
                    end
                end
                default:
                begin
                    if (zero_amt)
                    begin
                        shift_out.value = {carry_in, value[31:1]};
                        shift_out.carry = value[0];
                    end
                    else
                    begin
                        shift_out.value = ror_w[31:0];
                        shift_out.carry = ror_w[31];
                    end
                end
            endcase
        end
    end

endmodule

// ----- design/ash_alu.sv -----
module ash_alu (
    input  logic [31:0]          a,
    input  logic [31:0]          b,
    input  logic                 subtract,
    input  logic                 use_carry,
    input  logic                 carry_in,
    output ash_pkg::alu_out_t    alu_out
);
    import ash_pkg::*;

    logic [31:0] b_eff;
    logic        cin;
    logic [32:0] sum;

    // Subtraction is a + ~b + 1 (a + ~b + carry_in for SBC), so the carry out is the inverse of the borrow.
    assign b_eff = subtract ? ~b : b;
    assign cin   = use_carry ? carry_in : subtract;
    assign sum   = {1'b0, a} + {1'b0, b_eff} + {32'd0, cin};

    assign alu_out.value    = sum[31:0];
    assign alu_out.carry    = sum[32];
    assign alu_out.overflow = ~(a[SIGN_POS] ^ b_eff[SIGN_POS]) & (a[SIGN_POS] ^ sum[SIGN_POS]);

endmodule
